// File: src/crcdf_pkg.sv
// ----------------------------------------------------------------------------
// crcdf_pkg: shared types and helpers for the CRC-16 packet deframer
// Phase encoding, verdict codes, result record and the CRC-16/ARC byte step.
// ----------------------------------------------------------------------------
package crcdf_pkg;

    // Frame marker byte ('>') and marker run length
    localparam logic [7:0]  MARKER_BYTE  = 8'h3E;
    localparam logic [1:0]  MARKER_LAST  = 2'd2;   // count before the third marker
    localparam logic [2:0]  HDR_LAST_IDX = 3'd5;   // CRC low byte position

    // Header byte positions
    localparam logic [2:0]  HDR_TOPIC  = 3'd0;
    localparam logic [2:0]  HDR_SEQ    = 3'd1;
    localparam logic [2:0]  HDR_LEN_HI = 3'd2;
    localparam logic [2:0]  HDR_LEN_LO = 3'd3;
    localparam logic [2:0]  HDR_CRC_HI = 3'd4;

    // CRC-16/ARC, reflected polynomial
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Verdict codes
    localparam logic [1:0]  VERDICT_OPEN = 2'd0;
    localparam logic [1:0]  VERDICT_GOOD = 2'd1;
    localparam logic [1:0]  VERDICT_BAD  = 2'd2;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic [7:0]  topic;
        logic        is_payload;
        logic        last;
        logic [1:0]  verdict;
        logic [15:0] frame_length;
    } crcdf_res_t;

    // One CRC-16/ARC step over a byte (bitwise form of the table entry)
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] t;
        t = {8'h00, crc[7:0] ^ b};
        for (int i = 0; i < 8; i++)
        begin
            t = t[0] ? ((t >> 1) ^ CRC_POLY) : (t >> 1);
        end
        return {8'h00, crc[15:8]} ^ t;
    endfunction

endpackage

// File: src/crcdf_if.sv
// ----------------------------------------------------------------------------
// crcdf_if: request channels of the deframer
// Received byte channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface crcdf_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface crcdf_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic [7:0]  topic;
    logic        is_payload;
    logic        last;
    logic [1:0]  verdict;
    logic [15:0] frame_length;

    modport source (output valid, output payload_byte, output topic, output is_payload,
                    output last, output verdict, output frame_length, input ready);
    modport sink   (input valid, input payload_byte, input topic, input is_payload,
                    input last, input verdict, input frame_length, output ready);
endinterface

// File: src/crcdf_parser.sv
// ----------------------------------------------------------------------------
// crcdf_parser: frame state machine and CRC accumulator
// Hunts for the marker, reads the header, checks the payload CRC.
// ----------------------------------------------------------------------------
module crcdf_parser (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  logic [7:0]              byte_in,
    output logic                    emit,
    output crcdf_pkg::crcdf_res_t   res
);
    import crcdf_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [1:0]  marker_count_reg, marker_count_next;
    logic [2:0]  header_index_reg, header_index_next;
    logic [7:0]  topic_reg, topic_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] expected_crc_reg, expected_crc_next;
    logic [15:0] running_crc_reg, running_crc_next;
    logic [15:0] bytes_left_reg, bytes_left_next;

    // State registers, advance only on a step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HUNT;
            marker_count_reg <= '0;
            header_index_reg <= '0;
            topic_reg        <= '0;
            length_reg       <= '0;
            expected_crc_reg <= '0;
            running_crc_reg  <= '0;
            bytes_left_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            marker_count_reg <= marker_count_next;
            header_index_reg <= header_index_next;
            topic_reg        <= topic_next;
            length_reg       <= length_next;
            expected_crc_reg <= expected_crc_next;
            running_crc_reg  <= running_crc_next;
            bytes_left_reg   <= bytes_left_next;
        end
    end

    // Next state and result for the byte at hand
    always_comb
    begin
        phase_next        = phase_reg;
        marker_count_next = marker_count_reg;
        header_index_next = header_index_reg;
        topic_next        = topic_reg;
        length_next       = length_reg;
        expected_crc_next = expected_crc_reg;
        running_crc_next  = running_crc_reg;
        bytes_left_next   = bytes_left_reg;
        emit              = 1'b0;
        res               = '0;
        res.topic         = topic_reg;

        case (phase_reg)
            PH_HEADER:
            begin
                case (header_index_reg)
                    HDR_TOPIC:  topic_next = byte_in;
                    HDR_SEQ:    ;
                    HDR_LEN_HI: length_next = {byte_in, length_reg[7:0]};
                    HDR_LEN_LO: length_next = {length_reg[15:8], byte_in};
                    HDR_CRC_HI: expected_crc_next = {byte_in, expected_crc_reg[7:0]};
                    default:    expected_crc_next = {expected_crc_reg[15:8], byte_in};
                endcase
                if (header_index_reg < HDR_LAST_IDX)
                begin
                    header_index_next = header_index_reg + 3'd1;
                end
                else
                begin
                    header_index_next = '0;
                    running_crc_next  = '0;
                    if (length_next == 16'd0)
                    begin
                        // empty frame: single closing result
                        phase_next       = PH_HUNT;
                        emit             = 1'b1;
                        res.last         = 1'b1;
                        res.verdict      = (expected_crc_next == 16'd0) ? VERDICT_GOOD
                                                                        : VERDICT_BAD;
                    end
                    else
                    begin
                        bytes_left_next = length_next;
                        phase_next      = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                running_crc_next = crc_step(running_crc_reg, byte_in);
                bytes_left_next  = bytes_left_reg - 16'd1;
                emit             = 1'b1;
                res.payload_byte = byte_in;
                res.is_payload   = 1'b1;
                if (bytes_left_next == 16'd0)
                begin
                    phase_next       = PH_HUNT;
                    res.last         = 1'b1;
                    res.frame_length = length_reg;
                    res.verdict      = (running_crc_next == expected_crc_reg) ? VERDICT_GOOD
                                                                              : VERDICT_BAD;
                end
            end
            default:
            begin
                // hunting, also the unused phase code
                phase_next = PH_HUNT;
                if (byte_in == MARKER_BYTE)
                begin
                    if (marker_count_reg == MARKER_LAST)
                    begin
                        marker_count_next = '0;
                        header_index_next = '0;
                        phase_next        = PH_HEADER;
                    end
                    else
                    begin
                        marker_count_next = marker_count_reg + 2'd1;
                    end
                end
                else
                begin
                    marker_count_next = '0;
                end
            end
        endcase
    end

    // Checks
    a_hunt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HUNT) |-> !emit)
        else $error("result produced while hunting");

    a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (bytes_left_reg != 16'd0))
        else $error("payload phase with no bytes left");

    a_last_hunts: assert property (@(posedge clk) disable iff (!rst_n)
        (step && emit && res.last) |=> (phase_reg == PH_HUNT))
        else $error("frame closed without returning to hunt");

    a_hdr_index: assert property (@(posedge clk) disable iff (!rst_n)
        (header_index_reg <= HDR_LAST_IDX) && (marker_count_reg <= MARKER_LAST))
        else $error("header index or marker count out of range");

endmodule

// File: src/crcdf_out_buf.sv
// ----------------------------------------------------------------------------
// crcdf_out_buf: result register
// Holds one result until the sink takes it.
// ----------------------------------------------------------------------------
module crcdf_out_buf (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  crcdf_pkg::crcdf_res_t   data,
    output logic                    free,
    crcdf_res_if.source             res
);
    import crcdf_pkg::*;

    logic       valid_reg;
    crcdf_res_t data_reg;

    assign free = !valid_reg || res.ready;

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (free && load)
        begin
            data_reg <= data;
        end
    end

    assign res.valid        = valid_reg;
    assign res.payload_byte = data_reg.payload_byte;
    assign res.topic        = data_reg.topic;
    assign res.is_payload   = data_reg.is_payload;
    assign res.last         = data_reg.last;
    assign res.verdict      = data_reg.verdict;
    assign res.frame_length = data_reg.frame_length;

endmodule

// File: src/crc16_packet_deframer.sv
// ----------------------------------------------------------------------------
// crc16_packet_deframer: marker-framed packet deframer with CRC-16/ARC check
// Streams payload bytes with their topic; the last result carries the verdict.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                              | request
//  rx      | in  | rx_byte[7:0]                                         | one byte
//  res     | out | payload_byte, topic, is_payload, last, verdict,      | one result
//          |     | frame_length                                         |
//
//  One byte per clock sustained while results are taken; each byte passes the
//  input register, then the parser feeding the result register.
//  The CRC update is a single byte step between the input and result registers.
//  Marker and header bytes give no result; the byte ending a zero-length header
//  gives one. Reset (rst_n low, asynchronous) returns to hunting, no clearing pass.
//  A stalled result blocks only bytes that would produce a result.
// ----------------------------------------------------------------------------
module crc16_packet_deframer (
    input  logic        clk,
    input  logic        rst_n,
    crcdf_rx_if.sink    rx,
    crcdf_res_if.source res
);
    import crcdf_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       emit;
    logic       out_free;
    logic       advance;
    crcdf_res_t result;

    // Byte leaves the input register once its result has room, or when it gives no result
    assign advance  = in_valid_reg && (out_free || !emit);
    assign rx.ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            in_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            in_byte_reg <= rx.rx_byte;
        end
    end

    crcdf_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .byte_in (in_byte_reg),
        .emit    (emit),
        .res     (result)
    );

    crcdf_out_buf u_out_buf (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (advance && emit),
        .data  (result),
        .free  (out_free),
        .res   (res)
    );

    // Checks
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("held byte lost");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && emit) |-> out_free)
        else $error("result register overwritten");

    a_result_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && emit) |=> res.valid)
        else $error("result not presented");

endmodule
